[rtl/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants of the indexed list store
// Sizes, operation and status codes, and the command and status records
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int WORD_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int STAT_W   = 2;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_HEAD = 3'd0,
    MODE_PUSH_TAIL = 3'd1,
    MODE_INSERT    = 3'd2,
    MODE_POP_HEAD  = 3'd3,
    MODE_POP_TAIL  = 3'd4,
    MODE_EXTRACT   = 3'd5
  } mode_t;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  // Work set up for one operation when it is accepted.
  typedef struct packed {
    logic              dir_up;
    logic              capture_first;
    logic [ADDR_W-1:0] rd_start;
    logic [ADDR_W-1:0] rd_end;
    logic [ADDR_W-1:0] put_addr;
    status_t           status;
  } plan_t;

  typedef struct packed {
    logic  start;
    logic  rd_en;
    logic  put_wr;
    logic  cnt_inc;
    logic  cnt_dec;
    logic  load_out;
    plan_t plan;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             rd_last;
    logic             out_valid;
  } sts_t;

endpackage

[rtl/ils_in_if.sv]
// ----------------------------------------------------------------------------
// ils_in_if: operation request channel
// Valid/ready channel that carries one list operation per transfer.
// ----------------------------------------------------------------------------
interface ils_in_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] data_in;

  modport source (output valid, output mode, output position, output data_in,
                  input ready);
  modport sink   (input valid, input mode, input position, input data_in,
                  output ready);
endinterface

[rtl/ils_out_if.sv]
// ----------------------------------------------------------------------------
// ils_out_if: operation result channel
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface ils_out_if;
  import ils_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] data_out;
  logic [STAT_W-1:0]        status;
  logic [LEN_W-1:0]         length;
  logic                     is_empty;

  modport source (output valid, output data_out, output status, output length,
                  output is_empty, input ready);
  modport sink   (input valid, input data_out, input status, input length,
                  input is_empty, output ready);
endinterface

[rtl/ils_ram.sv]
// ----------------------------------------------------------------------------
// ils_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/ils_ctrl.sv]
// ----------------------------------------------------------------------------
// ils_ctrl: operation controller
// Checks each request against the current length, plans the entry moves
// and sequences the datapath through them.
// ----------------------------------------------------------------------------
module ils_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ils_pkg::MODE_W-1:0] mode,
  input  logic [ils_pkg::POS_W-1:0]  position,
  input  logic                      out_ready,
  input  ils_pkg::sts_t             sts,
  output ils_pkg::cmd_t             cmd
);
  import ils_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_PUT   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   put_r, put_nxt;

  plan_t            plan;
  state_t           go_state;
  logic             is_put;
  logic [CMP_W-1:0] cnt;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] p;

  assign cnt = CMP_W'(sts.count);
  assign pos = CMP_W'(position);

  // Request check and plan, from the current length.
  always_comb begin
    plan     = '0;
    go_state = S_DONE;
    is_put   = 1'b0;
    p        = '0;
    plan.status = ST_INVALID;
    unique case (mode)
      MODE_PUSH_HEAD, MODE_PUSH_TAIL, MODE_INSERT: begin
        is_put = 1'b1;
        if (mode == MODE_PUSH_HEAD) begin
          p = '0;
        end else if (mode == MODE_PUSH_TAIL) begin
          p = cnt;
        end else begin
          p = pos;
        end
        if (p > cnt) begin
          plan.status = ST_INVALID;
        end else if (cnt >= CMP_W'(CAPACITY)) begin
          plan.status = ST_FULL;
        end else begin
          plan.status   = ST_OK;
          plan.put_addr = ADDR_W'(p);
          plan.rd_start = ADDR_W'(cnt - CMP_W'(1));
          plan.rd_end   = ADDR_W'(p);
          go_state      = (p == cnt) ? S_PUT : S_READ;
        end
      end
      MODE_POP_HEAD, MODE_POP_TAIL, MODE_EXTRACT: begin
        if (mode == MODE_POP_HEAD) begin
          p = '0;
        end else if (mode == MODE_POP_TAIL) begin
          p = (cnt == '0) ? '0 : cnt - CMP_W'(1);
        end else begin
          p = pos;
        end
        if (cnt == '0 || p >= cnt) begin
          plan.status = ST_INVALID;
        end else begin
          plan.status        = ST_OK;
          plan.dir_up        = 1'b1;
          plan.capture_first = 1'b1;
          plan.rd_start      = ADDR_W'(p);
          plan.rd_end        = ADDR_W'(cnt - CMP_W'(1));
          go_state           = S_READ;
        end
      end
      default: begin
        plan.status = ST_INVALID;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    put_nxt   = put_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.plan  = plan;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          put_nxt   = is_put;
          state_nxt = go_state;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        if (sts.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (put_r) begin
          state_nxt = S_PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_PUT: begin
        cmd.put_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      put_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      put_r   <= put_nxt;
    end
  end

endmodule

[rtl/ils_dp.sv]
// ----------------------------------------------------------------------------
// ils_dp: list datapath
// Entry RAM, length counter, read/move pipeline and the result register.
// ----------------------------------------------------------------------------
module ils_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ils_pkg::cmd_t                    cmd,
  output ils_pkg::sts_t                    sts,
  input  logic signed [ils_pkg::WORD_W-1:0] data_in,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [ils_pkg::WORD_W-1:0] data_out,
  output logic [ils_pkg::STAT_W-1:0]        status,
  output logic [ils_pkg::LEN_W-1:0]         length,
  output logic                             is_empty
);
  import ils_pkg::*;

  // Control registers.
  logic             rd_pend_r, rd_pend_nxt;
  logic             pend_cap_r, pend_cap_nxt;
  logic             cap_r, cap_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Operation payload.
  logic                     dir_up_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  logic [ADDR_W-1:0]        end_r;
  logic [ADDR_W-1:0]        put_addr_r;
  logic [ADDR_W-1:0]        dst_r;
  status_t                  status_r;
  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] removed_r;

  // Result register.
  logic signed [WORD_W-1:0] out_data_r;
  status_t                  out_status_r;
  logic [LEN_W-1:0]         out_len_r;
  logic                     out_empty_r;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;

  // The write port serves both the moves and the final store of a new value;
  // the controller never asks for both in one cycle.
  assign ram_we    = (rd_pend_r && !pend_cap_r) || cmd.put_wr;
  assign ram_waddr = cmd.put_wr ? put_addr_r : dst_r;
  assign ram_wdata = cmd.put_wr ? data_r : ram_rdata;

  ils_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (rd_addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_pend_nxt   = cmd.rd_en;
    pend_cap_nxt  = cmd.rd_en && cap_r;
    cap_nxt       = cmd.start ? cmd.plan.capture_first : (cap_r && !cmd.rd_en);
    count_nxt     = count_r;
    if (cmd.cnt_inc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count_nxt = count_r - CNT_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      pend_cap_r  <= 1'b0;
      cap_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r   <= rd_pend_nxt;
      pend_cap_r  <= pend_cap_nxt;
      cap_r       <= cap_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dir_up_r   <= cmd.plan.dir_up;
      rd_addr_r  <= cmd.plan.rd_start;
      end_r      <= cmd.plan.rd_end;
      put_addr_r <= cmd.plan.put_addr;
      status_r   <= cmd.plan.status;
      data_r     <= DATA_W'(data_in);
      removed_r  <= '0;
    end else begin
      if (cmd.rd_en) begin
        rd_addr_r <= dir_up_r ? rd_addr_r + ADDR_W'(1) : rd_addr_r - ADDR_W'(1);
        dst_r     <= dir_up_r ? rd_addr_r - ADDR_W'(1) : rd_addr_r + ADDR_W'(1);
      end
      if (rd_pend_r && pend_cap_r) begin
        removed_r <= ram_rdata;
      end
    end
    if (cmd.load_out) begin
      out_data_r   <= WORD_W'(removed_r);
      out_status_r <= status_r;
      out_len_r    <= LEN_W'(count_r);
      out_empty_r  <= (count_r == '0);
    end
  end

  assign sts.count     = count_r;
  assign sts.rd_last   = (rd_addr_r == end_r);
  assign sts.out_valid = out_valid_r;

  assign out_valid = out_valid_r;
  assign data_out  = out_data_r;
  assign status    = out_status_r;
  assign length    = out_len_r;
  assign is_empty  = out_empty_r;

endmodule

[rtl/indexed_list_store_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_core: bounded ordered list of signed words
// Push, pop, insert and extract at head, tail or any position, with one
// result per request reporting the removed value, status and length.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                              | Handshake
//   --------+-----------+--------------------------------------+------------
//   in_ch   | in        | mode, position, data_in              | valid/ready
//   out_ch  | out       | data_out, status, length, is_empty   | valid/ready
//
// A rejected request goes straight to its result and a push at the tail needs
// no moves; insert at p and extract at p (pop head, pop tail) first shift the
// entries from p to the end of the list, as the entry RAM moves one entry per cycle.
// Reset clears the length and the handshake state only; entries past the
// length are never read, so the RAM needs no clearing pass. A stalled result
// waits in the output register while the next request runs to its final cycle.
// ----------------------------------------------------------------------------
module indexed_list_store_core (
  input  logic      clk,
  input  logic      rst_n,
  ils_in_if.sink    in_ch,
  ils_out_if.source out_ch
);
  import ils_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // The controller owns the sequence: it checks the request against the
  // length when the transfer happens, then steps the datapath through the
  // reads, the moves and the final store.
  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .mode      (in_ch.mode),
    .position  (in_ch.position),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the entries, the length and the result register.
  // Each move reads one entry and writes it one place over from the registered
  // read data, so reads and writes overlap and a shift runs at one entry per cycle.
  ils_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .data_in   (in_ch.data_in),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .data_out  (out_ch.data_out),
    .status    (out_ch.status),
    .length    (out_ch.length),
    .is_empty  (out_ch.is_empty)
  );

  assign in_ch.ready = in_ready;

  // The length can never pass the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= CNT_W'(CAPACITY))
    else $error("list length exceeds capacity");

  // A request is taken one at a time: after a transfer the input closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready) |=> !in_ready)
    else $error("input open right after a transfer");

  // The empty flag of a result agrees with its length.
  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.length == '0)))
    else $error("empty flag disagrees with length");

  // A full status is only reported with the list at capacity.
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_FULL) |->
      (out_ch.length == LEN_W'(CAPACITY)))
    else $error("full status below capacity");

  // A removed value is only reported on success.
  a_data_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.data_out == '0))
    else $error("nonzero data with an error status");

endmodule

[tb/sv/list_store_scoreboard.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// list_store_scoreboard: result checker for the indexed list store
// Watches the request and result channels, keeps a shadow copy of the list,
// predicts one result per accepted request and compares every result
// transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module list_store_scoreboard (
  input  logic clk,
  input  logic rst_n,
  ils_in_if    in_ch,
  ils_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import ils_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    status_t                  status;
    logic [LEN_W-1:0]         length;
    logic                     is_empty;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow [CAPACITY];
  int unsigned              shadow_len;
  list_result_t             predicted_q [$];

  // Opens a slot at pos and stores value there; later entries move toward
  // the tail. A bad position wins over a full list.
  function automatic status_t place_word(int unsigned pos,
                                         logic signed [DATA_W-1:0] value);
    int unsigned i;
    if (pos > shadow_len) return ST_INVALID;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (i = shadow_len; i > pos; i--) shadow[i] = shadow[i-1];
    shadow[pos] = value;
    shadow_len++;
    return ST_OK;
  endfunction

  // Removes the entry at pos and closes the gap behind it.
  function automatic status_t remove_word(int unsigned pos,
                                          output logic signed [DATA_W-1:0] value);
    int unsigned i;
    value = '0;
    if (shadow_len == 0 || pos >= shadow_len) return ST_INVALID;
    value = shadow[pos];
    for (i = pos; i + 1 < shadow_len; i++) shadow[i] = shadow[i+1];
    shadow_len--;
    return ST_OK;
  endfunction

  function automatic list_result_t predict_list_op(logic [MODE_W-1:0] mode,
                                                   logic [POS_W-1:0] pos,
                                                   logic signed [WORD_W-1:0] value);
    list_result_t             r;
    logic signed [DATA_W-1:0] removed;
    removed = '0;
    case (mode)
      MODE_PUSH_HEAD: r.status = place_word(0, value);
      MODE_PUSH_TAIL: r.status = place_word(shadow_len, value);
      MODE_INSERT:    r.status = place_word(pos, value);
      MODE_POP_HEAD:  r.status = remove_word(0, removed);
      MODE_POP_TAIL:  r.status = remove_word((shadow_len == 0) ? 0 : shadow_len - 1,
                                             removed);
      MODE_EXTRACT:   r.status = remove_word(pos, removed);
      default:        r.status = ST_INVALID;
    endcase
    r.data_out = removed;
    r.length   = shadow_len[LEN_W-1:0];
    r.is_empty = (shadow_len == 0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [WORD_W-1:0] want,
                               logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s wrong, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    shadow_len = 0;
  end

  // Results are checked before the request of the same edge is predicted,
  // since a result can never belong to a request accepted at that edge.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      shadow_len = 0;
      predicted_q.delete();
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (predicted_q.size() == 0) begin
          $display("%0t ns: result with none outstanding, expected nothing, actual %h %h %h %h",
                   $time, out_ch.data_out, out_ch.status, out_ch.length, out_ch.is_empty);
          fail_count++;
        end else begin
          want = predicted_q.pop_front();
          compare_field("data_out", want.data_out, out_ch.data_out);
          compare_field("status", WORD_W'(want.status), WORD_W'(out_ch.status));
          compare_field("length", WORD_W'(want.length), WORD_W'(out_ch.length));
          compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_ch.is_empty));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predicted_q.push_back(predict_list_op(in_ch.mode, in_ch.position, in_ch.data_in));
    end
    pending = predicted_q.size();
  end

endmodule

[tb/sv/indexed_list_store_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_list_store_core_test: top of the indexed list store testbench
// Drives list operations into the block, paces the result side, and gives
// the verdict from the failure count of the scoreboard beside the block.
// ----------------------------------------------------------------------------
module indexed_list_store_core_test;
  import ils_pkg::*;

  // The mode field is three bits wide, so the two codes past the last
  // operation can reach the block; it must answer them as invalid.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS   = 2000;
  localparam int PRESSURE_ITEMS = 24;
  // Long enough for the result register and the request behind it to fill.
  localparam int HOLD_CYCLES    = 400;
  // Enough for the block to finish its worst case request, a full shift.
  localparam int DRAIN_CYCLES   = 80;
  localparam int CYCLE_LIMIT    = 1_000_000;

  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  logic clk = 1'b0;
  logic rst_n;

  int   sender_idle_pct;
  int   receiver_stall_pct;
  logic pressure_req;
  logic pressure_done;
  int   hold_left;
  int   cycle_count;
  int   fail_count;
  int   pending;

  ils_in_if  in_ch ();
  ils_out_if out_ch ();

  indexed_list_store_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_store_scoreboard scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side. The stall percentage decides ready each cycle, except
  // during the one long hold-off: that is counted here, and while it runs
  // the sender keeps streaming so the block backs up and drops in_ch.ready.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (pressure_req && !pressure_done) begin
      out_ch.ready  <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one request starting at a falling edge and returns at the falling
  // edge after its transfer. Random idle cycles go in front of the request,
  // so valid stays high without a dip when no gap is drawn.
  task automatic offer_op(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                          input logic signed [WORD_W-1:0] value);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.position <= pos;
    in_ch.data_in  <= value;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
  endtask

  // Extreme words show up often enough to hit the sign boundary repeatedly.
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly positions near the head so inserts and extracts usually land
  // inside the list, some across the whole capacity, and a few anywhere in
  // the field so the top position bit gets exercised.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return POS_W'($urandom_range(0, 8));
    if (roll < 85) return POS_W'($urandom_range(0, CAPACITY + 2));
    return POS_W'($urandom_range(0, 2**POS_W - 1));
  endfunction

  // grow_pct is the share of adding operations; a few spare codes are mixed
  // in as noise. Position and data are random even where they are ignored.
  task automatic offer_random_op(input int grow_pct);
    int unsigned       roll;
    logic [MODE_W-1:0] mode;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      mode = roll[0] ? MODE_SPARE_HI : MODE_SPARE_LO;
    end else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_PUSH_HEAD;
        1:       mode = MODE_PUSH_TAIL;
        default: mode = MODE_INSERT;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       mode = MODE_POP_HEAD;
        1:       mode = MODE_POP_TAIL;
        default: mode = MODE_EXTRACT;
      endcase
    end
    offer_op(mode, pick_position(), pick_word());
  endtask

  // Alternating fill and drain bursts walk the length from empty up to the
  // full list and back, so both boundaries are hit again and again.
  task automatic run_bursts(input int items);
    int  sent;
    int  burst;
    int  k;
    bit  grow;
    sent = 0;
    grow = 1'b1;
    while (sent < items) begin
      burst = $urandom_range(40, 140);
      for (k = 0; k < burst && sent < items; k++) begin
        offer_random_op(grow ? 85 : 25);
        sent++;
      end
      grow = !grow;
    end
  endtask

  initial begin
    int sender_pcts [4];
    int receiver_pcts [4];
    int p;
    int i;
    sender_pcts   = '{0, 74, 0, 23};
    receiver_pcts = '{0, 0, 74, 23};

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = MODE_PUSH_HEAD;
    in_ch.position     = '0;
    in_ch.data_in      = '0;
    out_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    pressure_req       = 1'b0;
    pressure_done      = 1'b0;
    hold_left          = 0;
    cycle_count        = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: removals from the empty list, then a short list
    // built with every adding mode and taken apart again.
    offer_op(MODE_POP_HEAD, 7'd0, '0);
    offer_op(MODE_POP_TAIL, 7'd0, '0);
    offer_op(MODE_EXTRACT, 7'd0, '0);
    offer_op(MODE_INSERT, 7'd1, WORD_MAX);         // past the length: invalid
    offer_op(MODE_INSERT, 7'd0, WORD_MIN);         // at the length of an empty list
    offer_op(MODE_PUSH_TAIL, 7'd0, WORD_MAX);
    offer_op(MODE_PUSH_HEAD, 7'd0, '1);
    offer_op(MODE_INSERT, 7'd3, '0);               // at the length: appends
    offer_op(MODE_INSERT, 7'd1, 32'sh5A5A_A5A5);
    offer_op(MODE_INSERT, 7'd127, WORD_MIN);
    offer_op(MODE_INSERT, 7'd64, WORD_MAX);
    offer_op(MODE_EXTRACT, 7'd5, '0);              // at the length: invalid
    offer_op(MODE_EXTRACT, 7'd127, '1);
    offer_op(MODE_SPARE_LO, 7'd0, WORD_MAX);
    offer_op(MODE_SPARE_HI, 7'd127, WORD_MIN);
    offer_op(MODE_EXTRACT, 7'd2, '0);              // from the middle
    offer_op(MODE_EXTRACT, 7'd3, '0);              // the last entry
    offer_op(MODE_POP_TAIL, 7'd0, '0);
    offer_op(MODE_POP_HEAD, 7'd0, '0);
    offer_op(MODE_POP_HEAD, 7'd0, '0);             // leaves the list empty
    offer_op(MODE_POP_TAIL, 7'd0, '0);

    // Back-pressure: the receiver holds off while requests keep coming.
    pressure_req <= 1'b1;
    for (i = 0; i < PRESSURE_ITEMS; i++) offer_random_op(85);

    // Random traffic under each pacing mix in turn.
    for (p = 0; p < 4; p++) begin
      sender_idle_pct    <= sender_pcts[p];
      receiver_stall_pct <= receiver_pcts[p];
      run_bursts(RANDOM_ITEMS / 4);
    end

    in_ch.valid        <= 1'b0;
    receiver_stall_pct <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[indexed_list_store_core.f]
rtl/ils_pkg.sv
rtl/ils_in_if.sv
rtl/ils_out_if.sv
rtl/ils_ram.sv
rtl/ils_ctrl.sv
rtl/ils_dp.sv
rtl/indexed_list_store_core.sv
tb/sv/list_store_scoreboard.sv
tb/sv/indexed_list_store_core_test.sv
